// ----- design/kiss64_pkg.sv -----
// Package for the 64-bit KISS random generator.
// Constants, codes and state type used by kiss64_if and the top level; no dependencies.
`default_nettype none
package kiss64_pkg;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = 32;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [63:0] LCG_MUL  = 64'd1490024343005336237;
   localparam logic [63:0] LCG_ADD  = 64'd123456789;
   localparam logic [31:0] MWC1_MUL = 32'd4294584393;
   localparam logic [31:0] MWC2_MUL = 32'd4246477509;
   localparam int unsigned XS_A = 21;
   localparam int unsigned XS_B = 17;
   localparam int unsigned XS_C = 30;

   localparam logic [63:0] LCG_SEED_RST  = 64'd123456789987654321;
   localparam logic [63:0] XS_SEED_RST   = 64'd362436362436362436;
   localparam logic [31:0] MWC1_VAL_RST  = 32'd1066149217;
   localparam logic [31:0] MWC1_CAR_RST  = 32'd651600036;
   localparam logic [31:0] MWC2_VAL_RST  = 32'd1234567;
   localparam logic [31:0] MWC2_CAR_RST  = 32'd7654321;

   typedef enum logic [1:0] {
      ACT_RAW     = 2'd0,
      ACT_UNIFORM = 2'd1,
      ACT_RESEED  = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ZERO_BOUND = 2'd1,
      ST_BAD_SEED   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_LCG      = 3'd0,
      CSR_XS       = 3'd1,
      CSR_MWC1_VAL = 3'd2,
      CSR_MWC1_CAR = 3'd3,
      CSR_MWC2_VAL = 3'd4,
      CSR_MWC2_CAR = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_MUL,
      FSM_SUM,
      FSM_CHECK,
      FSM_LIM_WAIT,
      FSM_MOD_WAIT,
      FSM_RESP
   } fsm_type;
endpackage
`default_nettype wire

// ----- design/kiss64_if.sv -----
// Valid/ready channel interfaces for the KISS generator.
// Depends on kiss64_pkg for widths.
`default_nettype none
interface kiss64_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] upper_limit;
   modport source (output valid, action, upper_limit, input ready);
   modport sink (input valid, action, upper_limit, output ready);
endinterface

interface kiss64_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  status;
   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface

interface kiss64_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kiss64_pkg::CSR_IDX_W-1:0]    index;
   logic [63:0]                         data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/kiss64_mul.sv -----
// Shared 32x32 multiplier with registered product.
// No dependencies.
`default_nettype none
module kiss64_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic [63:0]      product
);
   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;
endmodule
`default_nettype wire

// ----- design/kiss64_div.sv -----
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module kiss64_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      remainder
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  count_ff, count_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [64:0] trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      trial    = {rem_ff, dvd_ff[63]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dvd_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 64'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[63:0];
         end
         dvd_in   = {dvd_ff[62:0], 1'b0};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ----- design/kiss64_random_generator_unit.sv -----
// Top level of the 64-bit KISS generator: sequencer, state, seed registers.
// Depends on kiss64_pkg, kiss64_if, kiss64_mul and kiss64_div.
//
// Usage: one transaction on req_chan gives exactly one on rsp_chan. The
// block takes a request only when idle and holds it until its response is
// taken. Seed registers are written on csr_chan (always ready), indexes 0..5;
// other indexes are dropped. Write them only while no request is open.
// A raw draw makes five passes through the shared 32x32 multiplier over six
// steps, then the sum. A uniform draw runs a remainder for the acceptance
// limit, repeats raw draws with a limit check until one falls below the
// limit, and runs a second remainder for the result. Reseed, zero bound and
// unused actions answer in the cycle after acceptance. The next request is
// taken in the cycle after the response transaction.
// Reset loads the documented seed values into both the seed registers and
// the generator state. A stalled receiver holds the response; no new
// request is taken until it is delivered.
`default_nettype none
module kiss64_random_generator_unit (
   input  wire logic clock,
   input  wire logic reset,
   kiss64_req_if.sink   req_chan,
   kiss64_rsp_if.source rsp_chan,
   kiss64_csr_if.sink   csr_chan
);
   kiss64_pkg::fsm_type fsm_ff, fsm_in;
   logic [2:0]  step_ff, step_in;
   logic        uniform_ff, uniform_in;
   logic [63:0] bound_ff, bound_in;
   logic [63:0] limit_ff, limit_in;
   logic [63:0] raw_ff, raw_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] value_ff, value_in;
   kiss64_pkg::status_type status_ff, status_in;

   logic [63:0] lcg_ff, lcg_in, xs_ff, xs_in;
   logic [31:0] m1v_ff, m1v_in, m1c_ff, m1c_in, m2v_ff, m2v_in, m2c_ff, m2c_in;

   logic [63:0] lcg_seed_ff, xs_seed_ff;
   logic [31:0] m1v_seed_ff, m1c_seed_ff, m2v_seed_ff, m2c_seed_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   logic        div_start, div_done;
   logic [63:0] div_dividend, remainder;
   logic [63:0] mwc_sum, xs_t1, xs_t2, xs_t3;
   logic        bad_seed;

   kiss64_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   kiss64_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (bound_ff),
      .done      (div_done),
      .remainder (remainder)
   );

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (fsm_ff == kiss64_pkg::FSM_IDLE);
   assign rsp_chan.valid = (fsm_ff == kiss64_pkg::FSM_RESP);
   assign rsp_chan.value = value_ff;
   assign rsp_chan.status = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_seed_ff <= kiss64_pkg::LCG_SEED_RST;
         xs_seed_ff  <= kiss64_pkg::XS_SEED_RST;
         m1v_seed_ff <= kiss64_pkg::MWC1_VAL_RST;
         m1c_seed_ff <= kiss64_pkg::MWC1_CAR_RST;
         m2v_seed_ff <= kiss64_pkg::MWC2_VAL_RST;
         m2c_seed_ff <= kiss64_pkg::MWC2_CAR_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            kiss64_pkg::CSR_LCG:      lcg_seed_ff <= csr_chan.data;
            kiss64_pkg::CSR_XS:       xs_seed_ff  <= csr_chan.data;
            kiss64_pkg::CSR_MWC1_VAL: m1v_seed_ff <= csr_chan.data[31:0];
            kiss64_pkg::CSR_MWC1_CAR: m1c_seed_ff <= csr_chan.data[31:0];
            kiss64_pkg::CSR_MWC2_VAL: m2v_seed_ff <= csr_chan.data[31:0];
            kiss64_pkg::CSR_MWC2_CAR: m2c_seed_ff <= csr_chan.data[31:0];
            default: ;
         endcase
      end
   end

   assign bad_seed = (xs_seed_ff == '0)
      || (m1v_seed_ff == '0 && m1c_seed_ff == '0)
      || (m2v_seed_ff == '0 && m2c_seed_ff == '0);

   assign xs_t1 = xs_ff ^ (xs_ff << kiss64_pkg::XS_A);
   assign xs_t2 = xs_t1 ^ (xs_t1 >> kiss64_pkg::XS_B);
   assign xs_t3 = xs_t2 ^ (xs_t2 << kiss64_pkg::XS_C);
   assign mwc_sum = product + 64'(step_ff == 3'd4 ? m1c_ff : m2c_ff);

   always_comb begin
      unique case (step_ff)
         3'd0: begin mul_a = lcg_ff[31:0];  mul_b = kiss64_pkg::LCG_MUL[31:0];  end
         3'd1: begin mul_a = lcg_ff[63:32]; mul_b = kiss64_pkg::LCG_MUL[31:0];  end
         3'd2: begin mul_a = lcg_ff[31:0];  mul_b = kiss64_pkg::LCG_MUL[63:32]; end
         3'd3: begin mul_a = m1v_ff;        mul_b = kiss64_pkg::MWC1_MUL;       end
         3'd4: begin mul_a = m2v_ff;        mul_b = kiss64_pkg::MWC2_MUL;       end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      fsm_in     = fsm_ff;
      step_in    = step_ff;
      uniform_in = uniform_ff;
      bound_in   = bound_ff;
      limit_in   = limit_ff;
      raw_in     = raw_ff;
      acc_in     = acc_ff;
      value_in   = value_ff;
      status_in  = status_ff;
      lcg_in = lcg_ff;  xs_in = xs_ff;
      m1v_in = m1v_ff;  m1c_in = m1c_ff;
      m2v_in = m2v_ff;  m2c_in = m2c_ff;
      div_start    = 1'b0;
      div_dividend = raw_ff;
      unique case (fsm_ff)
         kiss64_pkg::FSM_IDLE: begin
            if (req_chan.valid) begin
               bound_in   = req_chan.upper_limit;
               uniform_in = 1'b0;
               value_in   = '0;
               status_in  = kiss64_pkg::ST_OK;
               step_in    = '0;
               unique case (kiss64_pkg::action_type'(req_chan.action))
                  kiss64_pkg::ACT_RAW: fsm_in = kiss64_pkg::FSM_MUL;
                  kiss64_pkg::ACT_UNIFORM: begin
                     if (req_chan.upper_limit == '0) begin
                        status_in = kiss64_pkg::ST_ZERO_BOUND;
                        fsm_in    = kiss64_pkg::FSM_RESP;
                     end else begin
                        uniform_in = 1'b1;
                        fsm_in     = kiss64_pkg::FSM_LIM_WAIT;
                     end
                  end
                  kiss64_pkg::ACT_RESEED: begin
                     if (bad_seed) begin
                        status_in = kiss64_pkg::ST_BAD_SEED;
                     end else begin
                        lcg_in = lcg_seed_ff;  xs_in = xs_seed_ff;
                        m1v_in = m1v_seed_ff;  m1c_in = m1c_seed_ff;
                        m2v_in = m2v_seed_ff;  m2c_in = m2c_seed_ff;
                     end
                     fsm_in = kiss64_pkg::FSM_RESP;
                  end
                  default: fsm_in = kiss64_pkg::FSM_RESP;
               endcase
            end
         end
         kiss64_pkg::FSM_LIM_WAIT: begin
            div_dividend = '1;
            div_start    = (step_ff == 3'd0);
            step_in      = 3'd1;
            if (div_done) begin
               limit_in = ~remainder;
               step_in  = '0;
               fsm_in   = kiss64_pkg::FSM_MUL;
            end
         end
         kiss64_pkg::FSM_MUL: begin
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd1: acc_in = product;
               3'd2, 3'd3: acc_in = {acc_ff[63:32] + product[31:0], acc_ff[31:0]};
               3'd4: begin
                  m1v_in = mwc_sum[31:0];
                  m1c_in = mwc_sum[63:32];
               end
               3'd5: begin
                  m2v_in = mwc_sum[31:0];
                  m2c_in = mwc_sum[63:32];
                  lcg_in = acc_ff + kiss64_pkg::LCG_ADD;
                  xs_in  = xs_t3;
                  fsm_in = kiss64_pkg::FSM_SUM;
               end
               default: ;
            endcase
         end
         kiss64_pkg::FSM_SUM: begin
            raw_in = lcg_ff + xs_ff + 64'(m1v_ff) + {m2v_ff, 32'd0};
            if (uniform_ff) begin
               fsm_in = kiss64_pkg::FSM_CHECK;
            end else begin
               value_in = raw_in;
               fsm_in   = kiss64_pkg::FSM_RESP;
            end
         end
         kiss64_pkg::FSM_CHECK: begin
            step_in = '0;
            if (raw_ff >= limit_ff) begin
               fsm_in = kiss64_pkg::FSM_MUL;
            end else begin
               div_start = 1'b1;
               fsm_in    = kiss64_pkg::FSM_MOD_WAIT;
            end
         end
         kiss64_pkg::FSM_MOD_WAIT: begin
            if (div_done) begin
               value_in = remainder;
               fsm_in   = kiss64_pkg::FSM_RESP;
            end
         end
         kiss64_pkg::FSM_RESP: begin
            if (rsp_chan.ready) begin
               fsm_in = kiss64_pkg::FSM_IDLE;
            end
         end
         default: fsm_in = kiss64_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff  <= kiss64_pkg::FSM_IDLE;
         step_ff <= '0;
         lcg_ff  <= kiss64_pkg::LCG_SEED_RST;
         xs_ff   <= kiss64_pkg::XS_SEED_RST;
         m1v_ff  <= kiss64_pkg::MWC1_VAL_RST;
         m1c_ff  <= kiss64_pkg::MWC1_CAR_RST;
         m2v_ff  <= kiss64_pkg::MWC2_VAL_RST;
         m2c_ff  <= kiss64_pkg::MWC2_CAR_RST;
         uniform_ff <= 1'b0;
      end else begin
         fsm_ff  <= fsm_in;
         step_ff <= step_in;
         lcg_ff  <= lcg_in;
         xs_ff   <= xs_in;
         m1v_ff  <= m1v_in;
         m1c_ff  <= m1c_in;
         m2v_ff  <= m2v_in;
         m2c_ff  <= m2c_in;
         uniform_ff <= uniform_in;
      end
      bound_ff  <= bound_in;
      limit_ff  <= limit_in;
      raw_ff    <= raw_in;
      acc_ff    <= acc_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end
endmodule
`default_nettype wire

// ----- verif/kiss64_random_generator_unit_tb.sv -----
// Testbench for kiss64_random_generator_unit: drives draws, reseeds and seed
// writes, predicts every response with an in-bench KISS64 model and checks it.
// Depends on kiss64_pkg and the channel interfaces in kiss64_if.
`default_nettype none
module kiss64_random_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0]            value;
      kiss64_pkg::status_type status;
   } draw_result_type;

   class kiss_scoreboard;
      logic [63:0] seed_lcg, seed_xs;
      logic [31:0] seed_m1v, seed_m1c, seed_m2v, seed_m2c;
      logic [63:0] lcg, xs;
      logic [31:0] m1v, m1c, m2v, m2c;
      draw_result_type pending[$];
      int mismatches;

      function new();
         seed_lcg = kiss64_pkg::LCG_SEED_RST;
         seed_xs = kiss64_pkg::XS_SEED_RST;
         seed_m1v = kiss64_pkg::MWC1_VAL_RST;
         seed_m1c = kiss64_pkg::MWC1_CAR_RST;
         seed_m2v = kiss64_pkg::MWC2_VAL_RST;
         seed_m2c = kiss64_pkg::MWC2_CAR_RST;
         mismatches = 0;
         load_seeds();
      endfunction

      function void load_seeds();
         lcg = seed_lcg;
         xs = seed_xs;
         m1v = seed_m1v;
         m1c = seed_m1c;
         m2v = seed_m2v;
         m2c = seed_m2c;
      endfunction

      function void write_seed(kiss64_pkg::csr_idx_type idx, logic [63:0] data);
         case (idx)
            kiss64_pkg::CSR_LCG: seed_lcg = data;
            kiss64_pkg::CSR_XS: seed_xs = data;
            kiss64_pkg::CSR_MWC1_VAL: seed_m1v = data[31:0];
            kiss64_pkg::CSR_MWC1_CAR: seed_m1c = data[31:0];
            kiss64_pkg::CSR_MWC2_VAL: seed_m2v = data[31:0];
            kiss64_pkg::CSR_MWC2_CAR: seed_m2c = data[31:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] step_generators();
         logic [63:0] prod;
         lcg = kiss64_pkg::LCG_MUL * lcg + kiss64_pkg::LCG_ADD;
         xs = xs ^ (xs << kiss64_pkg::XS_A);
         xs = xs ^ (xs >> kiss64_pkg::XS_B);
         xs = xs ^ (xs << kiss64_pkg::XS_C);
         prod = 64'(kiss64_pkg::MWC1_MUL) * 64'(m1v) + 64'(m1c);
         m1c = prod[63:32];
         m1v = prod[31:0];
         prod = 64'(kiss64_pkg::MWC2_MUL) * 64'(m2v) + 64'(m2c);
         m2c = prod[63:32];
         m2v = prod[31:0];
         return lcg + xs + 64'(m1v) + {m2v, 32'd0};
      endfunction

      function void note_request(kiss64_pkg::action_type act, logic [63:0] bound);
         draw_result_type r;
         logic [63:0] lim, x;
         r.value = '0;
         r.status = kiss64_pkg::ST_OK;
         case (act)
            kiss64_pkg::ACT_RAW: r.value = step_generators();
            kiss64_pkg::ACT_UNIFORM: begin
               if (bound == 0) begin
                  r.status = kiss64_pkg::ST_ZERO_BOUND;
               end else begin
                  lim = ({64{1'b1}} / bound) * bound;
                  x = step_generators();
                  while (x >= lim) x = step_generators();
                  r.value = x % bound;
               end
            end
            kiss64_pkg::ACT_RESEED: begin
               if (seed_xs == 0 || (seed_m1v == 0 && seed_m1c == 0) ||
                   (seed_m2v == 0 && seed_m2c == 0))
                  r.status = kiss64_pkg::ST_BAD_SEED;
               else
                  load_seeds();
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function bit check_response(logic [63:0] value, logic [1:0] status);
         draw_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h/%0d", value, status);
            return 0;
         end
         e = pending.pop_front();
         if (value !== e.value || status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h/%0d got %h/%0d",
                        e.value, e.status, value, status);
            return 0;
         end
         return 1;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   kiss64_req_if req_chan();
   kiss64_rsp_if rsp_chan();
   kiss64_csr_if csr_chan();
   kiss_scoreboard sb = new();
   int send_idle = 0, recv_stall = 0, quiet_cycles = 0;
   bit timed_out = 0;

   kiss64_random_generator_unit uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.action = kiss64_pkg::ACT_RAW;
      req_chan.upper_limit = '0;
      rsp_chan.ready = 0;
      csr_chan.valid = 0;
      csr_chan.index = kiss64_pkg::CSR_LCG;
      csr_chan.data = '0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            void'(sb.check_response(rsp_chan.value, rsp_chan.status));
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles > 20000 && !timed_out) begin
         timed_out = 1;
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_request(kiss64_pkg::action_type act, logic [63:0] bound);
      if ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_chan.valid <= 1;
      req_chan.action <= act;
      req_chan.upper_limit <= bound;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(act, bound);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(kiss64_pkg::csr_idx_type idx, logic [63:0] data);
      csr_chan.valid <= 1;
      csr_chan.index <= idx;
      csr_chan.data <= data;
      do @(posedge clock); while (!csr_chan.ready);
      sb.write_seed(idx, data);
      csr_chan.valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_bound();
      case ($urandom_range(5))
         0: return 64'(1) << $urandom_range(63);
         1: return 64'($urandom_range(10));
         2: return ~64'($urandom_range(3));
         3: return 64'($urandom);
         default: return rand64();
      endcase
   endfunction

   task automatic random_seeds();
      for (int i = 0; i <= 5; i++) begin
         case ($urandom_range(5))
            0: write_csr(kiss64_pkg::csr_idx_type'(i), '0);
            1: write_csr(kiss64_pkg::csr_idx_type'(i), '1);
            default: write_csr(kiss64_pkg::csr_idx_type'(i), rand64());
         endcase
      end
   endtask

   initial begin
      kiss64_pkg::action_type act;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_request(kiss64_pkg::ACT_RAW, '0);
      send_request(kiss64_pkg::ACT_UNIFORM, '0);
      send_request(kiss64_pkg::ACT_UNIFORM, 64'd1);
      send_request(kiss64_pkg::ACT_UNIFORM, 64'd2);
      send_request(kiss64_pkg::ACT_UNIFORM, '1);
      send_request(kiss64_pkg::ACT_UNIFORM, 64'h8000_0000_0000_0001);
      send_request(kiss64_pkg::ACT_UNIFORM, 64'h8000_0000_0000_0000);
      send_request(kiss64_pkg::ACT_NONE, '1);
      send_request(kiss64_pkg::ACT_RESEED, '0);
      send_request(kiss64_pkg::ACT_RAW, '1);
      drain();
      write_csr(kiss64_pkg::CSR_XS, '0);
      send_request(kiss64_pkg::ACT_RESEED, '0);
      drain();
      write_csr(kiss64_pkg::CSR_XS, '1);
      write_csr(kiss64_pkg::CSR_MWC1_VAL, '0);
      write_csr(kiss64_pkg::CSR_MWC1_CAR, '0);
      send_request(kiss64_pkg::ACT_RESEED, '0);
      drain();
      write_csr(kiss64_pkg::CSR_MWC1_CAR, '1);
      write_csr(kiss64_pkg::CSR_MWC2_VAL, '0);
      write_csr(kiss64_pkg::CSR_MWC2_CAR, '0);
      send_request(kiss64_pkg::ACT_RESEED, '0);
      drain();
      write_csr(kiss64_pkg::CSR_MWC2_VAL, '1);
      write_csr(kiss64_pkg::CSR_LCG, '1);
      send_request(kiss64_pkg::ACT_RESEED, '0);
      send_request(kiss64_pkg::ACT_RAW, '0);
      send_request(kiss64_pkg::ACT_UNIFORM, 64'd3);
      drain();
      write_csr(kiss64_pkg::CSR_LCG, '0);
      write_csr(kiss64_pkg::CSR_MWC1_VAL, 64'd1);
      send_request(kiss64_pkg::ACT_RESEED, '0);
      send_request(kiss64_pkg::ACT_RAW, '0);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 63 : 21) : 0;
         recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 63 : 21) : 0;
         drain();
         random_seeds();
         for (int n = 0; n < 320; n++) begin
            case ($urandom_range(19))
               0: act = kiss64_pkg::ACT_RESEED;
               1: act = kiss64_pkg::ACT_NONE;
               2, 3, 4, 5, 6, 7, 8, 9: act = kiss64_pkg::ACT_UNIFORM;
               default: act = kiss64_pkg::ACT_RAW;
            endcase
            send_request(act, ($urandom_range(30) == 0) ? '0 : rand_bound());
            if (n == 150) drain();
         end
      end
      send_idle = 0;
      recv_stall = 0;
      drain();
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- kiss64_random_generator_unit.f -----
design/kiss64_pkg.sv
design/kiss64_if.sv
design/kiss64_mul.sv
design/kiss64_div.sv
design/kiss64_random_generator_unit.sv
verif/kiss64_random_generator_unit_tb.sv
